>>> rtl/pst_pkg.sv
package pst_pkg;

    localparam int MAX_USERS = 16;
    localparam int KEY_BYTES = 4;

    localparam int KEY_W    = 32;
    localparam int ACT_W    = 2;
    localparam int UNUM_W   = 5;
    localparam int STAT_W   = 2;
    localparam int UCNT_W   = 5;

    localparam int CNT_W    = $clog2(MAX_USERS + 1);
    localparam int ADDR_W   = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
    localparam int CMP_W    = (CNT_W > UNUM_W) ? CNT_W : UNUM_W;

    localparam int KEY_USED = (KEY_BYTES >= 4) ? 4 : KEY_BYTES;
    localparam logic [KEY_W-1:0] KEY_MASK =
        (KEY_USED >= 4) ? {KEY_W{1'b1}} : ({KEY_W{1'b1}} << (8 * (4 - KEY_USED)));

    localparam logic [ACT_W-1:0] ACT_CREATE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LOGIN  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADUSER = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_SCAN
    } state_t;

endpackage

>>> rtl/pst_ram.sv
module pst_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/password_table_store_match_unit.sv
// Password table with create, delete and login requests. Pulse start while busy is low to hand
// in an item; exactly one result follows, shown for one cycle with done high. The receiver cannot
// stall, so take granted, status and user_count in the done cycle. Create and rejected requests
// finish in the EXEC state, with no scan or shift. Login reads the table one entry per cycle
// through the single read port of the entry memory until it finds a match or has searched all
// entries. Delete of user n moves each later entry down through the memory, one read and
// one write per cycle. No clearing pass follows reset.
module password_table_store_match_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [pst_pkg::ACT_W-1:0]   action,
    input  logic [pst_pkg::KEY_W-1:0]   password,
    input  logic [pst_pkg::UNUM_W-1:0]  user_number,
    output logic                        done,
    output logic                        granted,
    output logic [pst_pkg::STAT_W-1:0]  status,
    output logic [pst_pkg::UCNT_W-1:0]  user_count
);

    pst_pkg::state_t state_reg, state_next;

    logic [pst_pkg::ACT_W-1:0]  act_reg;
    logic [pst_pkg::KEY_W-1:0]  key_reg;
    logic [pst_pkg::UNUM_W-1:0] unum_reg;

    logic [pst_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [pst_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic                       done_reg, done_next;
    logic                       granted_reg, granted_next;
    logic [pst_pkg::STAT_W-1:0] status_reg, status_next;

    logic                       wr_en;
    logic [pst_pkg::ADDR_W-1:0] wr_addr;
    logic [pst_pkg::KEY_W-1:0]  wr_data;
    logic                       rd_en;
    logic [pst_pkg::ADDR_W-1:0] rd_addr;
    logic [pst_pkg::KEY_W-1:0]  rd_data;

    logic [pst_pkg::CMP_W-1:0]  unum_ext;
    logic [pst_pkg::CMP_W-1:0]  cnt_ext;
    logic [pst_pkg::CNT_W-1:0]  idx_inc;
    logic                       create_full;
    logic                       del_bad;
    logic                       del_more;
    logic                       shift_more;
    logic                       scan_hit;
    logic                       scan_more;
    logic                       accept;

    assign accept      = start && (state_reg == pst_pkg::S_IDLE);
    assign unum_ext    = pst_pkg::CMP_W'(unum_reg);
    assign cnt_ext     = pst_pkg::CMP_W'(count_reg);
    assign idx_inc     = idx_reg + pst_pkg::CNT_W'(1);
    assign create_full = count_reg >= pst_pkg::CNT_W'(pst_pkg::MAX_USERS);
    assign del_bad     = (unum_reg == '0) || (unum_ext > cnt_ext);
    assign del_more    = unum_ext < cnt_ext;
    assign shift_more  = idx_inc < count_reg;
    assign scan_hit    = rd_data == key_reg;
    assign scan_more   = idx_reg < count_reg;

    pst_ram #(
        .DEPTH (pst_pkg::MAX_USERS),
        .WIDTH (pst_pkg::KEY_W),
        .AW    (pst_pkg::ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pst_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = pst_pkg::S_EXEC;
                end
            end
            pst_pkg::S_EXEC:
            begin
                state_next = pst_pkg::S_IDLE;
                if (act_reg == pst_pkg::ACT_DELETE && !del_bad && del_more)
                begin
                    state_next = pst_pkg::S_SHIFT;
                end
                else if (act_reg == pst_pkg::ACT_LOGIN && count_reg != '0)
                begin
                    state_next = pst_pkg::S_SCAN;
                end
            end
            pst_pkg::S_SHIFT:
            begin
                if (!shift_more)
                begin
                    state_next = pst_pkg::S_IDLE;
                end
            end
            pst_pkg::S_SCAN:
            begin
                if (scan_hit || !scan_more)
                begin
                    state_next = pst_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pst_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next   = count_reg;
        idx_next     = idx_reg;
        done_next    = 1'b0;
        granted_next = granted_reg;
        status_next  = status_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg[pst_pkg::ADDR_W-1:0];
        wr_data      = key_reg;
        rd_en        = 1'b0;
        rd_addr      = idx_reg[pst_pkg::ADDR_W-1:0];
        unique case (state_reg)
            pst_pkg::S_IDLE:
            begin
            end
            pst_pkg::S_EXEC:
            begin
                granted_next = 1'b0;
                status_next  = pst_pkg::ST_OK;
                done_next    = 1'b1;
                case (act_reg)
                    pst_pkg::ACT_CREATE:
                    begin
                        if (create_full)
                        begin
                            status_next = pst_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[pst_pkg::ADDR_W-1:0];
                            count_next = count_reg + pst_pkg::CNT_W'(1);
                        end
                    end
                    pst_pkg::ACT_DELETE:
                    begin
                        if (del_bad)
                        begin
                            status_next = pst_pkg::ST_BADUSER;
                        end
                        else if (del_more)
                        begin
                            done_next = 1'b0;
                            idx_next  = pst_pkg::CNT_W'(unum_reg);
                            rd_en     = 1'b1;
                            rd_addr   = pst_pkg::ADDR_W'(unum_reg);
                        end
                        else
                        begin
                            count_next = count_reg - pst_pkg::CNT_W'(1);
                        end
                    end
                    pst_pkg::ACT_LOGIN:
                    begin
                        if (count_reg != '0)
                        begin
                            done_next = 1'b0;
                            rd_en     = 1'b1;
                            rd_addr   = '0;
                            idx_next  = pst_pkg::CNT_W'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            pst_pkg::S_SHIFT:
            begin
                // move entry idx down to idx - 1, read the next one ahead
                wr_en   = 1'b1;
                wr_addr = idx_reg[pst_pkg::ADDR_W-1:0] - pst_pkg::ADDR_W'(1);
                wr_data = rd_data;
                if (shift_more)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_inc[pst_pkg::ADDR_W-1:0];
                    idx_next = idx_inc;
                end
                else
                begin
                    count_next = count_reg - pst_pkg::CNT_W'(1);
                    done_next  = 1'b1;
                end
            end
            pst_pkg::S_SCAN:
            begin
                if (scan_hit)
                begin
                    granted_next = 1'b1;
                    done_next    = 1'b1;
                end
                else if (scan_more)
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_inc;
                end
                else
                begin
                    done_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pst_pkg::S_IDLE;
            count_reg   <= '0;
            done_reg    <= 1'b0;
            granted_reg <= 1'b0;
            status_reg  <= pst_pkg::ST_OK;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
            granted_reg <= granted_next;
            status_reg  <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (accept)
        begin
            act_reg  <= action;
            key_reg  <= password & pst_pkg::KEY_MASK;
            unum_reg <= user_number;
        end
    end

    assign busy       = state_reg != pst_pkg::S_IDLE;
    assign done       = done_reg;
    assign granted    = granted_reg;
    assign status     = status_reg;
    assign user_count = pst_pkg::UCNT_W'(count_reg);

endmodule

>>> tb/password_table_store_match_unit_checker.sv
`timescale 1ns / 100ps

module password_table_store_match_unit_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [pst_pkg::ACT_W-1:0]   action,
    input  logic [pst_pkg::KEY_W-1:0]   password,
    input  logic [pst_pkg::UNUM_W-1:0]  user_number,
    input  logic                        done,
    input  logic                        granted,
    input  logic [pst_pkg::STAT_W-1:0]  status,
    input  logic [pst_pkg::UCNT_W-1:0]  user_count,
    output int                          fail_count,
    output int                          pending_count
);
    import pst_pkg::*;

    typedef struct packed {
        logic              granted;
        logic [STAT_W-1:0] status;
        logic [UCNT_W-1:0] user_count;
    } table_reply_t;

    logic [KEY_W-1:0] stored_keys [MAX_USERS];
    int               stored_users = 0;
    table_reply_t     expected_replies [$];
    int               failures = 0;

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
    end

    function automatic table_reply_t apply_request(input logic [ACT_W-1:0] act,
                                                   input logic [KEY_W-1:0] pw,
                                                   input logic [UNUM_W-1:0] unum);
        table_reply_t     reply;
        logic [KEY_W-1:0] key;
        int               idx;
        key              = pw & KEY_MASK;
        reply.granted    = 1'b0;
        reply.status     = ST_OK;
        case (act)
            ACT_CREATE:
            begin
                if (stored_users >= MAX_USERS)
                    reply.status = ST_FULL;
                else
                begin
                    stored_keys[stored_users] = key;
                    stored_users++;
                end
            end
            ACT_DELETE:
            begin
                if (unum == 0 || int'(unum) > stored_users)
                    reply.status = ST_BADUSER;
                else
                begin
                    for (idx = int'(unum); idx < stored_users; idx++)
                        stored_keys[idx-1] = stored_keys[idx];
                    stored_users--;
                end
            end
            ACT_LOGIN:
            begin
                for (idx = 0; idx < stored_users; idx++)
                    if (stored_keys[idx] == key)
                        reply.granted = 1'b1;
            end
            default:
            begin
            end
        endcase
        reply.user_count = stored_users[UCNT_W-1:0];
        return reply;
    endfunction

    always @(posedge clk)
    begin
        table_reply_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_replies.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: result with no item pending: granted %0b status %0d count %0d",
                                 $time, granted, status, user_count);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (granted !== want.granted || status !== want.status ||
                        user_count !== want.user_count)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display("%0t: mismatch: expected granted %0b status %0d count %0d, got granted %0b status %0d count %0d",
                                     $time, want.granted, want.status, want.user_count,
                                     granted, status, user_count);
                    end
                end
            end
            if (start && !busy)
                expected_replies.push_back(apply_request(action, password, user_number));
        end
        fail_count    <= failures;
        pending_count <= expected_replies.size();
    end

endmodule

>>> tb/password_table_store_match_unit_test.sv
`timescale 1ns / 100ps

module password_table_store_match_unit_test;
    import pst_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED  = 2'd3;
    localparam int               RANDOM_ITEMS = 1950;
    localparam int               CYCLE_LIMIT  = 500000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [ACT_W-1:0]    action = ACT_CREATE;
    logic [KEY_W-1:0]    password = '0;
    logic [UNUM_W-1:0]   user_number = '0;
    logic                busy;
    logic                done;
    logic                granted;
    logic [STAT_W-1:0]   status;
    logic [UCNT_W-1:0]   user_count;
    int                  fail_count;
    int                  pending_count;
    int                  cycle_count = 0;
    bit                  gaps_on = 1'b1;
    logic [KEY_W-1:0]    key_pool [8];

    password_table_store_match_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .password    (password),
        .user_number (user_number),
        .done        (done),
        .granted     (granted),
        .status      (status),
        .user_count  (user_count)
    );

    password_table_store_match_unit_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .password      (password),
        .user_number   (user_number),
        .done          (done),
        .granted       (granted),
        .status        (status),
        .user_count    (user_count),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // hold start high across back-to-back items; drop it only for a gap
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] pw,
                             input logic [UNUM_W-1:0] unum);
        int gap;
        gap = gaps_on ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        action      <= act;
        password    <= pw;
        user_number <= unum;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) < 7)
            return key_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic logic [UNUM_W-1:0] pick_user();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return UNUM_W'($urandom_range(17, 31));
        return UNUM_W'($urandom_range(1, 16));
    endfunction

    initial
    begin
        int               n;
        int               r;
        int               create_pct;
        int               delete_pct;
        logic [ACT_W-1:0] act;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (n = 2; n < 8; n++)
            key_pool[n] = $urandom;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(ACT_LOGIN, 32'h1234_5678, 5'd0);
        send_item(ACT_DELETE, 32'h0, 5'd1);
        send_item(ACT_DELETE, 32'h0, 5'd0);
        send_item(ACT_UNUSED, 32'hFFFF_FFFF, 5'd31);
        send_item(ACT_CREATE, 32'h0, 5'd0);
        send_item(ACT_CREATE, 32'hFFFF_FFFF, 5'd31);
        for (n = 0; n < MAX_USERS - 2; n++)
            send_item(ACT_CREATE, $urandom, UNUM_W'($urandom_range(0, 31)));
        send_item(ACT_CREATE, 32'hA5A5_A5A5, 5'd0);
        send_item(ACT_LOGIN, 32'hFFFF_FFFF, 5'd0);
        send_item(ACT_LOGIN, 32'h0, 5'd31);
        send_item(ACT_LOGIN, 32'h0000_0001, 5'd0);
        send_item(ACT_DELETE, 32'h0, 5'd31);
        send_item(ACT_DELETE, 32'h0, 5'd17);
        send_item(ACT_DELETE, 32'h0, 5'd16);
        send_item(ACT_DELETE, 32'h0, 5'd1);
        send_item(ACT_LOGIN, 32'h0, 5'd0);
        send_item(ACT_DELETE, 32'h0, 5'd0);
        send_item(ACT_UNUSED, 32'h0, 5'd0);

        create_pct = 30;
        delete_pct = 30;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            // shift the mix every phase so the table both fills and drains
            if (n % 64 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        create_pct = 45;
                        delete_pct = 20;
                    end
                    1:
                    begin
                        create_pct = 20;
                        delete_pct = 45;
                    end
                    default:
                    begin
                        create_pct = 30;
                        delete_pct = 30;
                    end
                endcase
                gaps_on = ($urandom_range(0, 2) != 0);
                key_pool[$urandom_range(2, 7)] = $urandom;
            end
            r = $urandom_range(0, 99);
            if (r < 3)
                act = ACT_UNUSED;
            else if (r < 3 + create_pct)
                act = ACT_CREATE;
            else if (r < 3 + create_pct + delete_pct)
                act = ACT_DELETE;
            else
                act = ACT_LOGIN;
            send_item(act, pick_key(), (act == ACT_DELETE) ? pick_user()
                                                           : UNUM_W'($urandom_range(0, 31)));
        end
        start <= 1'b0;

        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> password_table_store_match_unit.f
rtl/pst_pkg.sv
rtl/pst_ram.sv
rtl/password_table_store_match_unit.sv
tb/password_table_store_match_unit_checker.sv
tb/password_table_store_match_unit_test.sv
